// ----- rtl/core/sfi_pkg.sv -----
// shared types and constants for the sampled function interpolator
// no dependencies; every other file in rtl/core refers to this package by scoped name
`timescale 1ns / 1ps

package sfi_pkg;

    // bit position width: covers (65534 * 15 + 7) * 32
    localparam int POS_W = 25;
    // divider dividend width: 32 bit numerator shifted by 30, or 48 bit value by 14
    localparam int DIV_W = 62;

    // item op codes
    localparam logic [1:0] OP_WRITE_BYTE   = 2'd0;
    localparam logic [1:0] OP_WRITE_DECODE = 2'd1;
    localparam logic [1:0] OP_EVALUATE     = 2'd2;

    // register indexes
    localparam logic [2:0] REG_DOMAIN_LOW   = 3'd0;
    localparam logic [2:0] REG_DOMAIN_HIGH  = 3'd1;
    localparam logic [2:0] REG_ENCODE_LOW   = 3'd2;
    localparam logic [2:0] REG_ENCODE_HIGH  = 3'd3;
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd4;
    localparam logic [2:0] REG_SAMPLE_BITS  = 3'd5;
    localparam logic [2:0] REG_OUTPUT_COUNT = 3'd6;
    localparam logic [2:0] REG_SAMPLE_BYTES = 3'd7;

    // command class decided by the front end
    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_DECODE,
        KIND_EVAL
    } sfi_kind_t;

    typedef struct packed {
        sfi_kind_t          kind;
        logic [11:0]        byte_address;
        logic [7:0]         byte_value;
        logic [2:0]         channel;
        logic signed [31:0] decode_low;
        logic signed [31:0] decode_high;
        logic signed [31:0] x;
    } sfi_cmd_t;

    typedef struct packed {
        logic signed [31:0] domain_low;
        logic signed [31:0] domain_high;
        logic signed [31:0] encode_low;
        logic signed [31:0] encode_high;
        logic [15:0]        sample_count;
        logic [5:0]         sample_bits;
        logic [3:0]         output_count;
        logic [12:0]        sample_bytes;
    } sfi_cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [31:0]      divisor;
    } sfi_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } sfi_div_rsp_t;

    // back end sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MAP,
        ST_MAP_DIV,
        ST_SC_LO,
        ST_SC_HI,
        ST_SC_ACC,
        ST_SC_END,
        ST_CLAMP,
        ST_ROW,
        ST_BASE,
        ST_CH_START,
        ST_FETCH,
        ST_TAKE,
        ST_INTERP_MUL,
        ST_INTERP_SUM,
        ST_NORM_DIV,
        ST_EMIT
    } sfi_state_t;

endpackage

// ----- rtl/core/sampled_function_interpolator.sv -----
// top level: configuration registers on the APB port, front end, queue, back end, divider
// depends on sfi_pkg, sfi_front, sfi_queue, sfi_back and sfi_divider
//
// channel    signals                               beat moves
// item       item_valid/item_ready + op..x         one write or evaluate request
// result     result_valid/result_ready + value..   one channel result, last on final
// config     psel/penable/pwrite/paddr/pwdata      one register write or read
//
// a byte or decode write is done by the back end in its idle state
// an evaluation maps the domain through the divider and scale steps, skipped when degenerate,
// then per channel reads two samples byte by byte, interpolates, divides and scales; the one
// bit per cycle divider sets most of its length
// the two entry queue lets the item side keep going while the back end or result side stalls
// reset clears the registers, queue and decode tables; the sample memory needs no clearing
`timescale 1ns / 1ps

module sampled_function_interpolator #(
    parameter int MEM_BYTES   = 4096,
    parameter int MAX_OUTPUTS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         op,
    input  logic [11:0]        byte_address,
    input  logic [7:0]         byte_value,
    input  logic [2:0]         channel,
    input  logic signed [31:0] decode_low,
    input  logic signed [31:0] decode_high,
    input  logic signed [31:0] x,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] value,
    output logic [2:0]         out_channel,
    output logic               last
);

    sfi_pkg::sfi_cfg_t     cfg_reg;
    logic [2:0]            reg_idx;
    logic                  cfg_we;

    logic                  push;
    sfi_pkg::sfi_cmd_t     push_cmd;
    logic                  full;
    logic                  pop;
    sfi_pkg::sfi_cmd_t     pop_cmd;
    logic                  empty;
    sfi_pkg::sfi_div_req_t div_req;
    sfi_pkg::sfi_div_rsp_t div_rsp;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_we  = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.domain_low   <= 32'sd0;
            cfg_reg.domain_high  <= 32'sd65536;
            cfg_reg.encode_low   <= 32'sd0;
            cfg_reg.encode_high  <= 32'sd65536;
            cfg_reg.sample_count <= 16'd2;
            cfg_reg.sample_bits  <= 6'd8;
            cfg_reg.output_count <= 4'd1;
            cfg_reg.sample_bytes <= 13'd0;
        end
        else if (cfg_we)
        begin
            case (reg_idx)
                sfi_pkg::REG_DOMAIN_LOW:   cfg_reg.domain_low   <= pwdata;
                sfi_pkg::REG_DOMAIN_HIGH:  cfg_reg.domain_high  <= pwdata;
                sfi_pkg::REG_ENCODE_LOW:   cfg_reg.encode_low   <= pwdata;
                sfi_pkg::REG_ENCODE_HIGH:  cfg_reg.encode_high  <= pwdata;
                sfi_pkg::REG_SAMPLE_COUNT: cfg_reg.sample_count <= pwdata[15:0];
                sfi_pkg::REG_SAMPLE_BITS:  cfg_reg.sample_bits  <= pwdata[5:0];
                sfi_pkg::REG_OUTPUT_COUNT: cfg_reg.output_count <= pwdata[3:0];
                sfi_pkg::REG_SAMPLE_BYTES: cfg_reg.sample_bytes <= pwdata[12:0];
                default:                   cfg_reg.sample_bytes <= cfg_reg.sample_bytes;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (reg_idx)
            sfi_pkg::REG_DOMAIN_LOW:   prdata = cfg_reg.domain_low;
            sfi_pkg::REG_DOMAIN_HIGH:  prdata = cfg_reg.domain_high;
            sfi_pkg::REG_ENCODE_LOW:   prdata = cfg_reg.encode_low;
            sfi_pkg::REG_ENCODE_HIGH:  prdata = cfg_reg.encode_high;
            sfi_pkg::REG_SAMPLE_COUNT: prdata = 32'(cfg_reg.sample_count);
            sfi_pkg::REG_SAMPLE_BITS:  prdata = 32'(cfg_reg.sample_bits);
            sfi_pkg::REG_OUTPUT_COUNT: prdata = 32'(cfg_reg.output_count);
            sfi_pkg::REG_SAMPLE_BYTES: prdata = 32'(cfg_reg.sample_bytes);
            default:                   prdata = '0;
        endcase
    end

    sfi_front #(
        .MEM_BYTES   (MEM_BYTES),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_front (
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .op           (op),
        .byte_address (byte_address),
        .byte_value   (byte_value),
        .channel      (channel),
        .decode_low   (decode_low),
        .decode_high  (decode_high),
        .x            (x),
        .push         (push),
        .push_cmd     (push_cmd),
        .full         (full)
    );

    sfi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    sfi_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    sfi_back #(
        .MEM_BYTES   (MEM_BYTES),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .cmd_valid    (!empty),
        .cmd          (pop_cmd),
        .cmd_pop      (pop),
        .div_req      (div_req),
        .div_rsp      (div_rsp),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .value        (value),
        .out_channel  (out_channel),
        .last         (last)
    );

endmodule

// ----- rtl/core/sfi_divider.sv -----
// unsigned restoring divider, one quotient bit per cycle
// depends on sfi_pkg for the request and response structs
`timescale 1ns / 1ps

module sfi_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfi_pkg::sfi_div_req_t req,
    output sfi_pkg::sfi_div_rsp_t rsp
);

    localparam int DIV_W = sfi_pkg::DIV_W;

    logic [DIV_W-1:0] dvd_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      dsr_reg;
    logic [5:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [32:0]      rem_sh;
    logic             ge;
    logic [32:0]      rem_nx;

    // one shift and subtract step
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[DIV_W-1]};
        ge     = rem_sh >= {1'b0, dsr_reg};
        rem_nx = ge ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd0);
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIV_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == 6'd0)
                    busy_reg <= 1'b0;
                else
                    cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    // datapath: quotient bits shift in where the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
            rem_reg <= rem_nx[31:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

// ----- rtl/core/sfi_queue.sv -----
// two entry command queue between front end and back end
// depends on sfi_pkg for the command struct
`timescale 1ns / 1ps

module sfi_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sfi_pkg::sfi_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output sfi_pkg::sfi_cmd_t pop_cmd,
    output logic              empty
);

    sfi_pkg::sfi_cmd_t slot_reg [2];
    logic [1:0]        cnt_reg;
    logic              wr_reg;
    logic              rd_reg;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign pop_cmd = slot_reg[rd_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            if (push && !pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_cmd;
    end

endmodule

// ----- rtl/core/sfi_front.sv -----
// front end: takes input beats, classifies them and drops those with no effect
// depends on sfi_pkg for op codes and the command struct
`timescale 1ns / 1ps

module sfi_front #(
    parameter int MEM_BYTES   = 4096,
    parameter int MAX_OUTPUTS = 8
) (
    input  logic               item_valid,
    output logic               item_ready,
    input  logic [1:0]         op,
    input  logic [11:0]        byte_address,
    input  logic [7:0]         byte_value,
    input  logic [2:0]         channel,
    input  logic signed [31:0] decode_low,
    input  logic signed [31:0] decode_high,
    input  logic signed [31:0] x,
    output logic               push,
    output sfi_pkg::sfi_cmd_t  push_cmd,
    input  logic               full
);

    logic keep;

    // classify by op, filter writes that fall outside storage and drop unused op codes
    always_comb
    begin
        push_cmd.kind = sfi_pkg::KIND_EVAL;
        keep          = 1'b0;
        case (op)
            sfi_pkg::OP_WRITE_BYTE:
            begin
                push_cmd.kind = sfi_pkg::KIND_BYTE;
                keep          = 32'(byte_address) < 32'(MEM_BYTES);
            end
            sfi_pkg::OP_WRITE_DECODE:
            begin
                push_cmd.kind = sfi_pkg::KIND_DECODE;
                keep          = 32'(channel) < 32'(MAX_OUTPUTS);
            end
            sfi_pkg::OP_EVALUATE:
            begin
                push_cmd.kind = sfi_pkg::KIND_EVAL;
                keep          = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push_cmd.byte_address = byte_address;
    assign push_cmd.byte_value   = byte_value;
    assign push_cmd.channel      = channel;
    assign push_cmd.decode_low   = decode_low;
    assign push_cmd.decode_high  = decode_high;
    assign push_cmd.x            = x;

    assign item_ready = !full;
    assign push       = item_valid && !full && keep;

endmodule

// ----- rtl/core/sfi_back.sv -----
// back end: sample memory, decode tables and the evaluation sequencer
// depends on sfi_pkg; uses the shared divider through request/response structs
`timescale 1ns / 1ps

module sfi_back #(
    parameter int MEM_BYTES   = 4096,
    parameter int MAX_OUTPUTS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfi_pkg::sfi_cfg_t     cfg,
    input  logic                  cmd_valid,
    input  sfi_pkg::sfi_cmd_t     cmd,
    output logic                  cmd_pop,
    output sfi_pkg::sfi_div_req_t div_req,
    input  sfi_pkg::sfi_div_rsp_t div_rsp,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic signed [31:0]    value,
    output logic [2:0]            out_channel,
    output logic                  last
);

    localparam int POS_W = sfi_pkg::POS_W;
    localparam int AW    = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
    localparam int CW    = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam int TAB_N = 2 ** CW;

    sfi_pkg::sfi_state_t state_reg, state_next;

    // storage
    logic [7:0]         mem [MEM_BYTES];
    logic [7:0]         mem_q_reg;
    logic signed [31:0] low_tab_reg  [TAB_N];
    logic signed [31:0] high_tab_reg [TAB_N];

    // datapath registers
    logic signed [31:0] x_reg;
    logic               sc_out_reg;
    logic [31:0]        sc_mag_reg;
    logic               sc_neg_reg;
    logic [30:0]        sc_mult_reg;
    logic signed [31:0] sc_base_reg;
    logic [63:0]        acc_reg;
    logic signed [51:0] prod_reg;
    logic signed [35:0] e_reg;
    logic [15:0]        s0_reg;
    logic [15:0]        s1_reg;
    logic [15:0]        frac_reg;
    logic [19:0]        row0_reg;
    logic [19:0]        row1_reg;
    logic [POS_W-1:0]   base0_reg;
    logic [POS_W-1:0]   base1_reg;
    logic [POS_W-1:0]   coff_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [5:0]         rem_reg;
    logic [31:0]        v_reg;
    logic               sel_reg;
    logic [31:0]        raw0_reg;
    logic [31:0]        raw1_reg;
    logic [CW-1:0]      j_reg;
    logic signed [31:0] res_reg;
    logic               result_valid_reg;
    logic signed [31:0] value_reg;
    logic [2:0]         out_channel_reg;
    logic               last_reg;

    // effective configuration
    logic [15:0]        cnt_eff;
    logic [15:0]        cnt_m1;
    logic [5:0]         bits_eff;
    logic [3:0]         nout;
    logic [3:0]         nres;
    logic [31:0]        maxs;

    always_comb
    begin
        cnt_eff  = (cfg.sample_count < 16'd2) ? 16'd2 : cfg.sample_count;
        cnt_m1   = cnt_eff - 16'd1;
        bits_eff = (cfg.sample_bits == 6'd0) ? 6'd1 :
                   ((cfg.sample_bits > 6'd32) ? 6'd32 : cfg.sample_bits);
        nout     = (cfg.output_count == 4'd0) ? 4'd1 : cfg.output_count;
        nres     = (32'(nout) < 32'(MAX_OUTPUTS)) ? nout : 4'(MAX_OUTPUTS);
        maxs     = 32'((33'd1 << bits_eff) - 33'd1);
    end

    // domain mapping terms
    logic               degenerate;
    logic signed [31:0] x_clamp;
    logic [32:0]        map_num;
    logic [32:0]        map_den;
    logic signed [32:0] enc_diff;

    always_comb
    begin
        degenerate = !(cfg.domain_high > cfg.domain_low);
        if (x_reg < cfg.domain_low)
            x_clamp = cfg.domain_low;
        else if (x_reg > cfg.domain_high)
            x_clamp = cfg.domain_high;
        else
            x_clamp = x_reg;
        map_num  = 33'({x_clamp[31], x_clamp} - {cfg.domain_low[31], cfg.domain_low});
        map_den  = 33'({cfg.domain_high[31], cfg.domain_high}
                       - {cfg.domain_low[31], cfg.domain_low});
        enc_diff = {cfg.encode_high[31], cfg.encode_high}
                   - {cfg.encode_low[31], cfg.encode_low};
    end

    // decode scale terms for the current channel
    logic signed [31:0] dec_lo;
    logic signed [31:0] dec_hi;
    logic signed [32:0] dec_diff;
    logic [30:0]        vq;

    always_comb
    begin
        dec_lo   = low_tab_reg[j_reg];
        dec_hi   = high_tab_reg[j_reg];
        dec_diff = {dec_hi[31], dec_hi} - {dec_lo[31], dec_lo};
        vq       = (div_rsp.quotient > 62'd1073741824) ? 31'd1073741824
                                                       : div_rsp.quotient[30:0];
    end

    // end of scale: shift down, apply sign, add base, saturate
    logic [33:0]        sc_q;
    logic signed [35:0] sc_sres;
    logic signed [35:0] sc_sum;
    logic signed [31:0] sc_sat;

    always_comb
    begin
        sc_q    = acc_reg[63:30];
        sc_sres = sc_neg_reg ? -$signed({2'b00, sc_q}) : $signed({2'b00, sc_q});
        sc_sum  = $signed({{4{sc_base_reg[31]}}, sc_base_reg}) + sc_sres;
        if (sc_sum > 36'sd2147483647)
            sc_sat = 32'sh7fffffff;
        else if (sc_sum < -36'sd2147483648)
            sc_sat = 32'sh80000000;
        else
            sc_sat = sc_sum[31:0];
    end

    // clamp of the sample position
    logic [31:0]        top;
    logic [31:0]        e_clamp;
    logic [16:0]        s0_inc;

    always_comb
    begin
        top = {cnt_m1, 16'h0000};
        if (e_reg < 36'sd0)
            e_clamp = '0;
        else if (e_reg > $signed({4'b0000, top}))
            e_clamp = top;
        else
            e_clamp = e_reg[31:0];
        s0_inc = {1'b0, e_clamp[31:16]} + 17'd1;
    end

    // bit reader
    logic [POS_W-4:0]   fetch_byte;
    logic               fetch_stop;
    logic [2:0]         bit_off;
    logic [3:0]         avail;
    logic [3:0]         take_n;
    logic [7:0]         take_mask;
    logic [7:0]         take_field;
    logic [31:0]        v_next;

    always_comb
    begin
        fetch_byte = pos_reg[POS_W-1:3];
        fetch_stop = (rem_reg == 6'd0)
                     || (32'(fetch_byte) >= 32'(cfg.sample_bytes))
                     || (32'(fetch_byte) >= 32'(MEM_BYTES));
        bit_off    = pos_reg[2:0];
        avail      = 4'd8 - {1'b0, bit_off};
        take_n     = (rem_reg < 6'(avail)) ? rem_reg[3:0] : avail;
        take_mask  = 8'((9'd1 << take_n) - 9'd1);
        take_field = (mem_q_reg >> (avail - take_n)) & take_mask;
        v_next     = (v_reg << take_n) | 32'(take_field);
    end

    // interpolation sum and clamp at zero
    logic signed [52:0] interp_p;
    logic [47:0]        interp_v;

    always_comb
    begin
        interp_p = $signed({5'b00000, raw0_reg, 16'h0000})
                   + $signed({prod_reg[51], prod_reg});
        interp_v = (interp_p < 53'sd0) ? 48'd0 : interp_p[47:0];
    end

    // shared multiplier, product registered every cycle
    logic [16:0]        mul_a;
    logic signed [33:0] mul_b;
    logic signed [51:0] prod_next;

    assign prod_next = $signed({1'b0, mul_a}) * mul_b;

    // handshake with the output register
    logic load_out;
    logic is_last;

    assign is_last  = (6'(j_reg) + 6'd1) == 6'(nres);
    assign load_out = (state_reg == sfi_pkg::ST_EMIT) && (!result_valid_reg || result_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfi_pkg::ST_IDLE:
                if (cmd_valid && (cmd.kind == sfi_pkg::KIND_EVAL))
                    state_next = sfi_pkg::ST_MAP;
            sfi_pkg::ST_MAP:
                state_next = degenerate ? sfi_pkg::ST_CLAMP : sfi_pkg::ST_MAP_DIV;
            sfi_pkg::ST_MAP_DIV:
                if (div_rsp.done)
                    state_next = sfi_pkg::ST_SC_LO;
            sfi_pkg::ST_SC_LO:
                state_next = sfi_pkg::ST_SC_HI;
            sfi_pkg::ST_SC_HI:
                state_next = sfi_pkg::ST_SC_ACC;
            sfi_pkg::ST_SC_ACC:
                state_next = sfi_pkg::ST_SC_END;
            sfi_pkg::ST_SC_END:
                state_next = sc_out_reg ? sfi_pkg::ST_EMIT : sfi_pkg::ST_CLAMP;
            sfi_pkg::ST_CLAMP:
                state_next = sfi_pkg::ST_ROW;
            sfi_pkg::ST_ROW:
                state_next = sfi_pkg::ST_BASE;
            sfi_pkg::ST_BASE:
                state_next = sfi_pkg::ST_CH_START;
            sfi_pkg::ST_CH_START:
                state_next = sfi_pkg::ST_FETCH;
            sfi_pkg::ST_FETCH:
                if (!fetch_stop)
                    state_next = sfi_pkg::ST_TAKE;
                else if (sel_reg)
                    state_next = sfi_pkg::ST_INTERP_MUL;
            sfi_pkg::ST_TAKE:
                state_next = sfi_pkg::ST_FETCH;
            sfi_pkg::ST_INTERP_MUL:
                state_next = sfi_pkg::ST_INTERP_SUM;
            sfi_pkg::ST_INTERP_SUM:
                state_next = sfi_pkg::ST_NORM_DIV;
            sfi_pkg::ST_NORM_DIV:
                if (div_rsp.done)
                    state_next = sfi_pkg::ST_SC_LO;
            sfi_pkg::ST_EMIT:
                if (load_out)
                    state_next = is_last ? sfi_pkg::ST_IDLE : sfi_pkg::ST_CH_START;
            default:
                state_next = sfi_pkg::ST_IDLE;
        endcase
    end

    // control outputs per state
    logic mem_we;
    logic mem_re;

    always_comb
    begin
        cmd_pop          = 1'b0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {map_num[31:0], 30'd0};
        div_req.divisor  = map_den[31:0];
        mul_a            = sc_mag_reg[16:0];
        mul_b            = $signed({3'b000, sc_mult_reg});
        case (state_reg)
            sfi_pkg::ST_IDLE:
            begin
                cmd_pop = cmd_valid;
                mem_we  = cmd_valid && (cmd.kind == sfi_pkg::KIND_BYTE);
            end
            sfi_pkg::ST_MAP:
            begin
                div_req.start = !degenerate;
            end
            sfi_pkg::ST_SC_LO:
            begin
                mul_a = sc_mag_reg[16:0];
            end
            sfi_pkg::ST_SC_HI:
            begin
                mul_a = {2'b00, sc_mag_reg[31:17]};
            end
            sfi_pkg::ST_FETCH:
            begin
                mem_re = !fetch_stop;
            end
            sfi_pkg::ST_INTERP_MUL:
            begin
                mul_a = {1'b0, frac_reg};
                mul_b = $signed({2'b00, raw1_reg}) - $signed({2'b00, raw0_reg});
            end
            sfi_pkg::ST_INTERP_SUM:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {interp_v, 14'd0};
                div_req.divisor  = maxs;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    // sample memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[AW'(cmd.byte_address)] <= cmd.byte_value;
        if (mem_re)
            mem_q_reg <= mem[AW'(fetch_byte)];
    end

    // state, decode tables and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= sfi_pkg::ST_IDLE;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < TAB_N; i++)
            begin
                low_tab_reg[i]  <= 32'sd0;
                high_tab_reg[i] <= 32'sd65536;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
            if ((state_reg == sfi_pkg::ST_IDLE) && cmd_valid
                && (cmd.kind == sfi_pkg::KIND_DECODE))
            begin
                low_tab_reg[CW'(cmd.channel)]  <= cmd.decode_low;
                high_tab_reg[CW'(cmd.channel)] <= cmd.decode_high;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        case (state_reg)
            sfi_pkg::ST_IDLE:
            begin
                x_reg <= cmd.x;
            end
            sfi_pkg::ST_MAP:
            begin
                e_reg <= $signed({{4{cfg.encode_low[31]}}, cfg.encode_low});
            end
            sfi_pkg::ST_MAP_DIV:
            begin
                sc_out_reg  <= 1'b0;
                sc_mult_reg <= div_rsp.quotient[30:0];
                sc_neg_reg  <= enc_diff[32];
                sc_mag_reg  <= enc_diff[32] ? 32'(-enc_diff) : enc_diff[31:0];
                sc_base_reg <= cfg.encode_low;
            end
            sfi_pkg::ST_SC_HI:
            begin
                acc_reg <= {16'h0000, prod_reg[47:0]};
            end
            sfi_pkg::ST_SC_ACC:
            begin
                acc_reg <= acc_reg + ({16'h0000, prod_reg[47:0]} << 17);
            end
            sfi_pkg::ST_SC_END:
            begin
                e_reg   <= sc_sum;
                res_reg <= sc_sat;
            end
            sfi_pkg::ST_CLAMP:
            begin
                s0_reg   <= e_clamp[31:16];
                frac_reg <= e_clamp[15:0];
                s1_reg   <= (s0_inc < {1'b0, cnt_eff}) ? s0_inc[15:0] : e_clamp[31:16];
            end
            sfi_pkg::ST_ROW:
            begin
                row0_reg <= 20'(s0_reg) * 20'(nout);
                row1_reg <= 20'(s1_reg) * 20'(nout);
            end
            sfi_pkg::ST_BASE:
            begin
                base0_reg <= POS_W'(26'(row0_reg) * 26'(bits_eff));
                base1_reg <= POS_W'(26'(row1_reg) * 26'(bits_eff));
                coff_reg  <= '0;
                j_reg     <= '0;
            end
            sfi_pkg::ST_CH_START:
            begin
                pos_reg <= base0_reg + coff_reg;
                rem_reg <= bits_eff;
                v_reg   <= '0;
                sel_reg <= 1'b0;
            end
            sfi_pkg::ST_FETCH:
            begin
                if (fetch_stop)
                begin
                    if (!sel_reg)
                    begin
                        raw0_reg <= v_reg;
                        pos_reg  <= base1_reg + coff_reg;
                        rem_reg  <= bits_eff;
                        v_reg    <= '0;
                        sel_reg  <= 1'b1;
                    end
                    else
                    begin
                        raw1_reg <= v_reg;
                    end
                end
            end
            sfi_pkg::ST_TAKE:
            begin
                v_reg   <= v_next;
                pos_reg <= pos_reg + POS_W'(take_n);
                rem_reg <= rem_reg - 6'(take_n);
            end
            sfi_pkg::ST_NORM_DIV:
            begin
                sc_out_reg  <= 1'b1;
                sc_mult_reg <= vq;
                sc_neg_reg  <= dec_diff[32];
                sc_mag_reg  <= dec_diff[32] ? 32'(-dec_diff) : dec_diff[31:0];
                sc_base_reg <= dec_lo;
            end
            sfi_pkg::ST_EMIT:
            begin
                if (load_out)
                begin
                    value_reg       <= res_reg;
                    out_channel_reg <= 3'(j_reg);
                    last_reg        <= is_last;
                    j_reg           <= j_reg + CW'(1);
                    coff_reg        <= coff_reg + POS_W'(bits_eff);
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign out_channel  = out_channel_reg;
    assign last         = last_reg;

endmodule

// ----- tb/testbench.sv -----
// testbench for sampled_function_interpolator: directed, random and backpressure tests
// depends on sfi_pkg and the rtl top level; holds its own fixed point predictor
`timescale 1ns / 1ps

module testbench;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 40;
    // bytes loaded up front; every configuration keeps sample_bytes within them
    localparam int FILL_BYTES     = 48;

    typedef struct {
        logic signed [31:0] value;
        logic [2:0]         ch;
        logic               last;
    } channel_result_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               item_valid;
    logic               item_ready;
    logic [1:0]         op;
    logic [11:0]        byte_address;
    logic [7:0]         byte_value;
    logic [2:0]         channel;
    logic signed [31:0] decode_low;
    logic signed [31:0] decode_high;
    logic signed [31:0] x;
    logic               result_valid;
    logic               result_ready;
    logic signed [31:0] value;
    logic [2:0]         out_channel;
    logic               last;

    // mirror of the block state
    sfi_pkg::sfi_cfg_t  cfg;
    logic [7:0]         sample_mem [4096];
    logic signed [31:0] dec_low_tab [8];
    logic signed [31:0] dec_high_tab [8];

    channel_result_t    pending_results [$];
    int                 errors = 0;
    int                 idle_cycles = 0;
    bit                 fast_sender;
    bit                 quiet_receiver;
    int                 hold_request = 0;

    sampled_function_interpolator uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .item_valid(item_valid), .item_ready(item_ready),
        .op(op), .byte_address(byte_address), .byte_value(byte_value),
        .channel(channel), .decode_low(decode_low), .decode_high(decode_high), .x(x),
        .result_valid(result_valid), .result_ready(result_ready),
        .value(value), .out_channel(out_channel), .last(last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // diff * r / 2^30 truncated toward zero
    function automatic longint scale_by_q30(longint diff, longint unsigned r);
        longint unsigned mag;
        longint unsigned prod;
        mag  = (diff < 0) ? longint'(-diff) : longint'(diff);
        prod = (mag * r) >> 30;
        return (diff < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // packed sample fetch, msb first, stopping at the valid byte limit
    function automatic longint unsigned fetch_sample(longint unsigned bitpos, int bits);
        longint unsigned lim;
        longint unsigned pos;
        longint unsigned v;
        lim = (cfg.sample_bytes < 4096) ? cfg.sample_bytes : 4096;
        v = 0;
        for (int i = 0; i < bits; i++)
        begin
            pos = bitpos + i;
            if ((pos >> 3) >= lim)
                break;
            v = (v << 1) | ((sample_mem[pos >> 3] >> (7 - (pos & 7))) & 1);
        end
        return v;
    endfunction

    // expected channel values for one evaluation
    function automatic void predict_evaluation(logic signed [31:0] xin);
        longint unsigned count, nout, nres, s0, s1, frac, maxs, num, den, r, raw0, raw1, vq;
        int bits;
        longint xv, dl, dh, e, top, p, lo, hi, res;
        channel_result_t item;
        count = (cfg.sample_count < 2) ? 2 : cfg.sample_count;
        bits  = (cfg.sample_bits == 0) ? 1 :
                ((cfg.sample_bits > 32) ? 32 : int'(cfg.sample_bits));
        nout  = (cfg.output_count == 0) ? 1 : cfg.output_count;
        nres  = (nout < 8) ? nout : 8;
        xv = longint'(xin);
        dl = longint'($signed(cfg.domain_low));
        dh = longint'($signed(cfg.domain_high));
        if (dh > dl)
        begin
            if (xv < dl) xv = dl;
            if (xv > dh) xv = dh;
            num = xv - dl;
            den = dh - dl;
            r = (num << 30) / den;
            e = longint'($signed(cfg.encode_low)) + scale_by_q30(
                longint'($signed(cfg.encode_high)) - longint'($signed(cfg.encode_low)), r);
        end
        else
            e = longint'($signed(cfg.encode_low));
        top = longint'((count - 1) << 16);
        if (e < 0) e = 0;
        if (e > top) e = top;
        s0   = e >> 16;
        frac = e & 64'hFFFF;
        s1   = (s0 + 1 < count) ? s0 + 1 : s0;
        maxs = (bits >= 32) ? 64'hFFFF_FFFF : ((64'd1 << bits) - 1);
        for (longint unsigned j = 0; j < nres; j++)
        begin
            raw0 = fetch_sample((s0 * nout + j) * bits, bits);
            raw1 = fetch_sample((s1 * nout + j) * bits, bits);
            p = longint'(raw0 << 16) + longint'(frac) * (longint'(raw1) - longint'(raw0));
            if (p < 0) p = 0;
            vq = (longint'(p) << 14) / maxs;
            if (vq > (64'd1 << 30)) vq = 64'd1 << 30;
            lo  = longint'(dec_low_tab[j]);
            hi  = longint'(dec_high_tab[j]);
            res = lo + scale_by_q30(hi - lo, vq);
            if (res > 64'sd2147483647) res = 64'sd2147483647;
            if (res < -64'sd2147483648) res = -64'sd2147483648;
            item.value = res[31:0];
            item.ch    = j[2:0];
            item.last  = (j + 1 == nres);
            pending_results.push_back(item);
        end
    endfunction

    // send one item beat and update the predictor on acceptance
    task automatic send_item(logic [1:0] code, logic [11:0] addr, logic [7:0] bval,
                             logic [2:0] ch, logic signed [31:0] dlo,
                             logic signed [31:0] dhi, logic signed [31:0] xin);
        int gap;
        gap = fast_sender ? 0 : $urandom_range(0, 18);
        repeat (gap) @(negedge clk) item_valid = 1'b0;
        @(negedge clk);
        item_valid = 1'b1; op = code; byte_address = addr; byte_value = bval;
        channel = ch; decode_low = dlo; decode_high = dhi; x = xin;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        case (code)
            sfi_pkg::OP_WRITE_BYTE:   sample_mem[addr] = bval;
            sfi_pkg::OP_WRITE_DECODE:
            begin
                dec_low_tab[ch]  = dlo;
                dec_high_tab[ch] = dhi;
            end
            sfi_pkg::OP_EVALUATE:     predict_evaluation(xin);
            default: ;
        endcase
        @(negedge clk) item_valid = 1'b0;
    endtask

    task automatic send_random_word_item(logic [1:0] code);
        send_item(code, 12'($urandom), 8'($urandom), 3'($urandom),
                  $urandom, $urandom, $urandom);
    endtask

    // wait for all results, then let any trailing write settle
    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb register write, setup then access
    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = data;
        @(negedge clk) penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            sfi_pkg::REG_DOMAIN_LOW:   cfg.domain_low   = data;
            sfi_pkg::REG_DOMAIN_HIGH:  cfg.domain_high  = data;
            sfi_pkg::REG_ENCODE_LOW:   cfg.encode_low   = data;
            sfi_pkg::REG_ENCODE_HIGH:  cfg.encode_high  = data;
            sfi_pkg::REG_SAMPLE_COUNT: cfg.sample_count = data[15:0];
            sfi_pkg::REG_SAMPLE_BITS:  cfg.sample_bits  = data[5:0];
            sfi_pkg::REG_OUTPUT_COUNT: cfg.output_count = data[3:0];
            sfi_pkg::REG_SAMPLE_BYTES: cfg.sample_bytes = data[12:0];
            default: ;
        endcase
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_config(logic [31:0] dlo, logic [31:0] dhi, logic [31:0] elo,
                              logic [31:0] ehi, logic [15:0] cnt, logic [5:0] bits,
                              logic [3:0] nout, logic [12:0] nbytes);
        wait_drained();
        write_reg(sfi_pkg::REG_DOMAIN_LOW, dlo);
        write_reg(sfi_pkg::REG_DOMAIN_HIGH, dhi);
        write_reg(sfi_pkg::REG_ENCODE_LOW, elo);
        write_reg(sfi_pkg::REG_ENCODE_HIGH, ehi);
        write_reg(sfi_pkg::REG_SAMPLE_COUNT, {16'd0, cnt});
        write_reg(sfi_pkg::REG_SAMPLE_BITS, {26'd0, bits});
        write_reg(sfi_pkg::REG_OUTPUT_COUNT, {28'd0, nout});
        write_reg(sfi_pkg::REG_SAMPLE_BYTES, {19'd0, nbytes});
    endtask

    // the readable bytes are written first so no evaluation ever reads unwritten memory
    task automatic test_fill_memory();
        fast_sender = 1'b1;
        for (int a = 0; a < FILL_BYTES; a++)
            send_item(sfi_pkg::OP_WRITE_BYTE, a[11:0], 8'($urandom), 0, 0, 0, 0);
        fast_sender = 1'b0;
    endtask

    task automatic test_directed();
        // reset defaults with no valid bytes
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh0000_8000);
        // decode bound extremes
        send_item(sfi_pkg::OP_WRITE_DECODE, 0, 0, 3'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_item(sfi_pkg::OP_WRITE_DECODE, 0, 0, 3'd7, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
        send_item(sfi_pkg::OP_WRITE_BYTE, 12'hFFF, 8'hFF, 0, 0, 0, 0);
        send_item(OP_UNUSED, 12'h000, 8'h00, 3'd7, 0, 0, 0);
        set_config(32'hFFFF_0000, 32'h0001_0000, 0, 32'h0004_0000, 5, 8, 8, 13'(FILL_BYTES));
        // x extremes and clamping at both domain ends
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh8000_0000);
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF);
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh0000_4321);
        // degenerate domain, one bit samples, zero channels, tiny count
        set_config(32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 0, 1, 1, 0, 1);
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh1234_5678);
        // encode beyond the top, 32 bit samples, stride above the channel limit
        set_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   16'd32768, 6'd63, 4'd15, 13'(FILL_BYTES));
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 0);
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF);
        // bits zero, short memory, count zero
        set_config(0, 32'h0010_0000, 0, 32'h0003_0000, 0, 0, 3, 2);
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh0008_0000);
        set_config(0, 32'h0010_0000, 32'h0000_2000, 32'h0007_E000, 8, 24, 2, 7);
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh0004_1000);
        send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, 32'sh0010_0000);
    endtask

    task automatic randomize_config();
        logic [31:0] dlo, elo;
        logic [15:0] cnt;
        logic [5:0]  bits;
        dlo = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 32'h40000)) - 32'h20000;
        cnt = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(2, 40));
        elo = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h20000);
        case ($urandom_range(0, 7))
            0: bits = 1;  1: bits = 2;  2: bits = 4;  3: bits = 8;
            4: bits = 16; 5: bits = 24; 6: bits = 32;
            default: bits = 6'($urandom);
        endcase
        set_config(dlo,
                   $urandom_range(0, 5) == 0 ? $urandom : dlo + $urandom_range(1, 32'h80000),
                   elo,
                   $urandom_range(0, 3) == 0 ? $urandom : {cnt, 16'h0} - $urandom_range(0, 32'h30000),
                   cnt, bits, 4'($urandom_range(0, 15)),
                   $urandom_range(0, 3) == 0 ? 13'($urandom_range(0, FILL_BYTES))
                                             : 13'(FILL_BYTES));
    endtask

    task automatic test_random();
        int kind;
        for (int phase = 0; phase < 8; phase++)
        begin
            randomize_config();
            quiet_receiver = (phase == 3);
            for (int k = 0; k < 6; k++)
            begin
                kind = $urandom_range(0, 19);
                if (kind < 11)
                    send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0,
                              $urandom_range(0, 3) == 0 ? $urandom :
                              $signed(cfg.domain_low) + $signed($urandom_range(0, 32'h90000))
                              - 32'h8000);
                else if (kind < 16)
                    send_random_word_item(sfi_pkg::OP_WRITE_BYTE);
                else if (kind < 19)
                    send_random_word_item(sfi_pkg::OP_WRITE_DECODE);
                else
                    send_random_word_item(OP_UNUSED);
            end
        end
        quiet_receiver = 1'b0;
    endtask

    // long receiver hold while the sender keeps offering evaluations
    task automatic test_backpressure();
        wait_drained();
        set_config(0, 32'h0002_0000, 0, 32'h0003_0000, 4, 8, 2, 13'(FILL_BYTES));
        hold_request = 400;
        fast_sender = 1'b1;
        for (int k = 0; k < 10; k++)
            send_item(sfi_pkg::OP_EVALUATE, 0, 0, 0, 0, 0, $urandom_range(0, 32'h20000));
        fast_sender = 1'b0;
    endtask

    // result checker with random stalls
    initial
    begin
        channel_result_t exp_item;
        int stall;
        bit hold_taken;
        hold_taken = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            stall = quiet_receiver ? 0 : $urandom_range(0, 18);
            if (hold_request != 0 && !hold_taken)
            begin
                stall = hold_request;
                hold_taken = 1'b1;
            end
            repeat (stall) @(negedge clk) result_ready = 1'b0;
            @(negedge clk) result_ready = 1'b1;
            @(posedge clk);
            while (!result_valid)
                @(posedge clk);
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result beat: value %h channel %0d", $time, value,
                         out_channel);
            end
            else
            begin
                exp_item = pending_results.pop_front();
                if (value !== exp_item.value)
                begin
                    errors++;
                    $display("%0t value mismatch: expected %h actual %h", $time,
                             exp_item.value, value);
                end
                if (out_channel !== exp_item.ch)
                begin
                    errors++;
                    $display("%0t channel mismatch: expected %0d actual %0d", $time,
                             exp_item.ch, out_channel);
                end
                if (last !== exp_item.last)
                begin
                    errors++;
                    $display("%0t last mismatch: expected %b actual %b", $time,
                             exp_item.last, last);
                end
            end
        end
    end

    // watchdog on cycles with no beat
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        fast_sender = 1'b0; quiet_receiver = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        item_valid = 1'b0; op = sfi_pkg::OP_WRITE_BYTE; byte_address = '0; byte_value = '0;
        channel = '0; decode_low = '0; decode_high = '0; x = '0;
        cfg = '{domain_low: 0, domain_high: 32'h10000, encode_low: 0,
                encode_high: 32'h10000, sample_count: 2, sample_bits: 8,
                output_count: 1, sample_bytes: 0};
        for (int c = 0; c < 8; c++)
        begin
            dec_low_tab[c]  = 0;
            dec_high_tab[c] = 32'sh0001_0000;
        end
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_fill_memory();
        test_directed();
        test_random();
        test_backpressure();

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
